// File: rtl/ffha_pkg.sv
package ffha_pkg;

    // response status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    // operation codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // field widths
    localparam int REQ_W  = 13;
    localparam int ADDR_W = 12;

    // controller to datapath
    typedef struct packed {
        logic       accept;     // latch request payload
        logic       start;      // init heap if needed, reset walk, round request
        logic       rd_cur;     // read header at walk offset
        logic       capture;    // register header read data
        logic       advance;    // step walk to next block
        logic       rd_next;    // read header of following block
        logic       wr_alloc;   // mark current block used with new size
        logic       wr_rest;    // write split remainder header
        logic       wr_merge;   // write freed block, merged with next
        logic       wr_prev;    // grow previous free block
        logic       set_res;    // latch result
        logic [1:0] res_status;
        logic       load_out;   // move result to output register
    } ffha_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_free;
        logic req_zero;
        logic inited;
        logic fits;
        logic match;
        logic cur_used;
        logic at_end;
        logic prev_free;
        logic out_free;
    } ffha_stat_t;

endpackage

// File: rtl/ffha_if.sv
interface ffha_in_if import ffha_pkg::*;;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, cmd, request_bytes, free_address, input ready);
    modport sink   (input valid, cmd, request_bytes, free_address, output ready);
endinterface

interface ffha_out_if import ffha_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] address;

    modport source (output valid, status, address, input ready);
    modport sink   (input valid, status, address, output ready);
endinterface

// File: rtl/ffha_datapath.sv
module ffha_datapath import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ffha_cmd_t         ctl,
    output ffha_stat_t        stat,
    input  logic              in_cmd,
    input  logic [REQ_W-1:0]  in_request_bytes,
    input  logic [ADDR_W-1:0] in_free_address,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        out_status,
    output logic [ADDR_W-1:0] out_address
);

    // sizes and offsets are kept in units of the alignment
    localparam int NSLOT = (HEAP_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int HDR_U = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int SW    = $clog2(NSLOT);
    localparam int UW    = $clog2(NSLOT + 1);
    localparam int NW    = UW + 1;
    localparam int QW    = REQ_W + 1;
    localparam int CW    = ((QW > UW) ? QW : UW) + 1;
    localparam int PW    = $clog2((NSLOT + HDR_U) * ALIGN_BYTES + 1);
    localparam int MW    = (PW > ADDR_W) ? PW : ADDR_W;
    // reciprocal of the alignment, exact for every QW-bit dividend
    localparam int RSH   = QW + $clog2(ALIGN_BYTES) + 1;
    localparam int RMUL  = ((1 << RSH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int PRW   = QW + RSH;

    // header memory: used bit over size
    logic [UW:0] mem [NSLOT];
    logic [UW:0] rdata_reg;

    logic              cmd_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              init_reg, init_next;
    logic [QW-1:0]     q_reg;
    logic [UW-1:0]     off_reg, prev_reg;
    logic [UW-1:0]     cur_sz_reg, prev_sz_reg, merged_reg;
    logic              cur_used_reg, prev_used_reg, has_prev_reg, nxt_ok_reg;
    logic [1:0]        res_status_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg;
    logic [ADDR_W-1:0] out_address_reg;

    logic [QW-1:0]  rnd;
    logic [PRW-1:0] rprod;
    logic [QW-1:0]  need_u;
    logic [NW-1:0]  nxt;
    logic [MW-1:0]  pay_b;
    logic [UW-1:0]  merged;
    logic           wr_en;
    logic [SW-1:0]  wr_addr;
    logic [UW:0]    wr_data;
    logic [SW-1:0]  rd_addr;
    logic           rd_en;
    logic           wr_init;

    // walk arithmetic
    assign nxt    = NW'(off_reg) + NW'(HDR_U) + NW'(cur_sz_reg);
    assign pay_b  = (MW'(off_reg) + MW'(HDR_U)) * MW'(ALIGN_BYTES);
    assign merged = cur_sz_reg + ((nxt_ok_reg && !rdata_reg[UW])
                    ? (UW'(HDR_U) + rdata_reg[UW-1:0]) : '0);

    // request rounded up to whole alignment units
    assign rnd    = QW'(req_reg) + QW'(ALIGN_BYTES - 1);
    assign rprod  = PRW'(rnd) * PRW'(RMUL);
    assign need_u = rprod[PRW-1:RSH];

    assign wr_init = ctl.start && (cmd_reg == CMD_ALLOC) && !init_reg;

    // status to controller
    always_comb
    begin
        stat.is_free   = cmd_reg == CMD_FREE;
        stat.req_zero  = req_reg == '0;
        stat.inited    = init_reg;
        stat.fits      = (CW'(q_reg) + CW'(HDR_U)) <= CW'(cur_sz_reg);
        stat.match     = pay_b == MW'(addr_reg);
        stat.cur_used  = cur_used_reg;
        stat.at_end    = nxt >= NW'(NSLOT);
        stat.prev_free = has_prev_reg && !prev_used_reg;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // memory write port select
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = {1'b0, UW'(NSLOT - HDR_U)};
        if (ctl.wr_alloc)
        begin
            wr_addr = off_reg[SW-1:0];
            wr_data = {1'b1, q_reg[UW-1:0]};
        end
        else if (ctl.wr_rest)
        begin
            wr_addr = SW'(off_reg + UW'(HDR_U) + q_reg[UW-1:0]);
            wr_data = {1'b0, cur_sz_reg - q_reg[UW-1:0] - UW'(HDR_U)};
        end
        else if (ctl.wr_merge)
        begin
            wr_addr = off_reg[SW-1:0];
            wr_data = {1'b0, merged};
        end
        else if (ctl.wr_prev)
        begin
            wr_addr = prev_reg[SW-1:0];
            wr_data = {1'b0, prev_sz_reg + UW'(HDR_U) + merged_reg};
        end
        else if (!wr_init)
        begin
            wr_en = 1'b0;
        end
    end

    assign rd_en   = ctl.rd_cur || ctl.rd_next;
    assign rd_addr = ctl.rd_next ? nxt[SW-1:0] : off_reg[SW-1:0];

    // header memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= in_cmd;
            req_reg  <= in_request_bytes;
            addr_reg <= in_free_address;
        end
        if (ctl.start)
        begin
            q_reg   <= need_u;
            off_reg <= '0;
        end
        else if (ctl.advance)
        begin
            off_reg       <= nxt[UW-1:0];
            prev_reg      <= off_reg;
            prev_sz_reg   <= cur_sz_reg;
            prev_used_reg <= cur_used_reg;
        end
        if (ctl.capture)
        begin
            cur_sz_reg   <= rdata_reg[UW-1:0];
            cur_used_reg <= rdata_reg[UW];
        end
        if (ctl.rd_next)
        begin
            nxt_ok_reg <= nxt < NW'(NSLOT);
        end
        if (ctl.wr_merge)
        begin
            merged_reg <= merged;
        end
        if (ctl.set_res)
        begin
            res_status_reg <= ctl.res_status;
            res_addr_reg   <= (ctl.res_status == ST_OK && cmd_reg == CMD_ALLOC)
                              ? pay_b[ADDR_W-1:0] : '0;
        end
        if (ctl.load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_address_reg <= res_addr_reg;
        end
    end

    // control registers
    always_comb
    begin
        init_next = init_reg || wr_init;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            has_prev_reg  <= 1'b0;
        end
        else
        begin
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
            if (ctl.start)
            begin
                has_prev_reg <= 1'b0;
            end
            else if (ctl.advance)
            begin
                has_prev_reg <= 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_address = out_address_reg;

endmodule

// File: rtl/ffha_ctrl.sv
module ffha_ctrl import ffha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ffha_stat_t stat,
    output ffha_cmd_t  ctl
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CAP   = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_WREST = 4'd6;
    localparam logic [3:0] S_MRG   = 4'd7;
    localparam logic [3:0] S_WPREV = 4'd8;
    localparam logic [3:0] S_RESP  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_START;
                end
            end
            // reject early cases, else set up the walk
            S_START:
            begin
                if (!stat.is_free && stat.req_zero)
                begin
                    ctl.set_res    = 1'b1;
                    ctl.res_status = ST_ZERO;
                    state_next     = S_RESP;
                end
                else if (stat.is_free && !stat.inited)
                begin
                    ctl.set_res    = 1'b1;
                    ctl.res_status = ST_NOTFOUND;
                    state_next     = S_RESP;
                end
                else
                begin
                    ctl.start  = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                ctl.rd_cur = 1'b1;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                ctl.capture = 1'b1;
                state_next  = S_EVAL;
            end
            // decide on the current block
            S_EVAL:
            begin
                if (!stat.is_free && !stat.cur_used && stat.fits)
                begin
                    ctl.wr_alloc = 1'b1;
                    state_next   = S_WREST;
                end
                else if (stat.is_free && stat.match)
                begin
                    if (stat.cur_used)
                    begin
                        ctl.rd_next = 1'b1;
                        state_next  = S_MRG;
                    end
                    else
                    begin
                        ctl.set_res    = 1'b1;
                        ctl.res_status = ST_NOTFOUND;
                        state_next     = S_RESP;
                    end
                end
                else if (stat.at_end)
                begin
                    ctl.set_res    = 1'b1;
                    ctl.res_status = stat.is_free ? ST_NOTFOUND : ST_NOFIT;
                    state_next     = S_RESP;
                end
                else
                begin
                    ctl.advance = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_WREST:
            begin
                ctl.wr_rest    = 1'b1;
                ctl.set_res    = 1'b1;
                ctl.res_status = ST_OK;
                state_next     = S_RESP;
            end
            S_MRG:
            begin
                ctl.wr_merge = 1'b1;
                if (stat.prev_free)
                begin
                    state_next = S_WPREV;
                end
                else
                begin
                    ctl.set_res    = 1'b1;
                    ctl.res_status = ST_OK;
                    state_next     = S_RESP;
                end
            end
            S_WPREV:
            begin
                ctl.wr_prev    = 1'b1;
                ctl.set_res    = 1'b1;
                ctl.res_status = ST_OK;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator with coalescing. The heap is a chain of blocks, each a header
// followed by its payload; one header per alignment slot lives in an on-chip memory, and
// after reset the first allocate of a nonzero size lays the heap out as one free block. An
// allocate rounds the request up to whole alignment units with a reciprocal multiply, then
// walks the chain from offset 0; a free walks to the block whose payload starts at the given
// address and merges it with free neighbours. A zero-size allocate, or a free before the heap
// is laid out, is answered without a walk; otherwise the walk reads one header per memory
// access and visits blocks until one fits or matches or the chain ends. A hit on a free
// writes the merged block and, when the previous block is free, grows that block as well. A
// finished response waits until the output register is free. A new request is taken while
// the previous response still waits at the output.
module first_fit_heap_allocator import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 24
)
(
    input logic       clk,
    input logic       rst_n,
    ffha_in_if.sink   request,
    ffha_out_if.source response
);

    ffha_cmd_t  ctl;
    ffha_stat_t stat;

    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    ffha_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .in_cmd           (request.cmd),
        .in_request_bytes (request.request_bytes),
        .in_free_address  (request.free_address),
        .out_valid        (response.valid),
        .out_ready        (response.ready),
        .out_status       (response.status),
        .out_address      (response.address)
    );

    // at most one header write per cycle
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.start, ctl.wr_alloc, ctl.wr_rest, ctl.wr_merge, ctl.wr_prev}))
        else $error("two header writes in one cycle");

    // an accept always drops ready, so no request is taken while busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("request accepted while busy");

    // failed responses carry a zero address
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && response.status != ST_OK) |-> response.address == '0)
        else $error("nonzero address on failed response");

    // output loads only when the register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> (!response.valid || response.ready))
        else $error("response overwritten");

endmodule
